[hw/rtl/pli_pkg.sv]
package pli_pkg;

  // list geometry
  localparam int DEPTH   = 32;
  localparam int INDEX_W = $clog2(DEPTH);
  localparam int COUNT_W = $clog2(DEPTH + 1);

  // field widths
  localparam int OP_W      = 3;
  localparam int VALUE_W   = 32;
  localparam int POS_W     = 8;
  localparam int CNT_OUT_W = 6;
  localparam int STATUS_W  = 2;

  // position compare width: holds both a position and count + 1
  localparam int CMP_W = ((COUNT_W > POS_W) ? COUNT_W : POS_W) + 1;

  // stream widths
  localparam int S_TDATA_W = 40;
  localparam int S_TUSER_W = OP_W;
  localparam int M_TDATA_W = 40;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_POS   = 3'd2,
    OP_DEL_FRONT = 3'd3,
    OP_DEL_BACK  = 3'd4,
    OP_DEL_POS   = 3'd5,
    OP_DISPLAY   = 3'd6
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_BADPOS = 2'd1,
    STAT_EMPTY  = 2'd2,
    STAT_FULL   = 2'd3
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic exec;        // apply the accepted operation, load its result beat
    logic disp_start;  // rewind the readout index
    logic disp_load;   // load the entry at the readout index, step the index
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic disp_run;    // accepted op is a display of a non-empty list
    logic disp_last;   // readout index points at the back entry
  } sts_t;

endpackage

[hw/rtl/positional_list_insert_delete.sv]
// Positional list of up to DEPTH (32) signed 32-bit values, front at position 1.
// Each input beat carries one operation: insert at front, back or a 1-based
// position, delete at front, back or a position, or display. Insert and delete
// shift all cells in parallel, and each answers with a single beat holding the
// new count and a status (ok, bad position, empty, full).
// Display streams the list front to back, one beat per entry with tlast on the
// back entry, one cell per cycle while the output register can take a beat.
// A display of an empty list answers with one beat, status empty.
// The block takes a new operation only after the previous one has issued all
// its beats, and while the output register is free or being drained.
module positional_list_insert_delete (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [pli_pkg::S_TDATA_W-1:0]   s_tdata,   // [31:0] value, [39:32] position
  input  logic [pli_pkg::S_TUSER_W-1:0]   s_tuser,   // [2:0] opcode
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [pli_pkg::M_TDATA_W-1:0]   m_tdata,   // [31:0] value_out, [37:32] count,
                                                     // [39:38] status
  output logic                            m_tuser,   // [0] value_valid
  output logic                            m_tlast
);
  import pli_pkg::*;

  cmd_t                      cmd;
  sts_t                      sts;
  logic signed [VALUE_W-1:0] value_out;
  logic [CNT_OUT_W-1:0]      count;
  logic [STATUS_W-1:0]       status;

  pli_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pli_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .opcode      (s_tuser[OP_W-1:0]),
    .value       (s_tdata[VALUE_W-1:0]),
    .position    (s_tdata[VALUE_W+POS_W-1:VALUE_W]),
    .value_out   (value_out),
    .value_valid (m_tuser),
    .count       (count),
    .status      (status),
    .last        (m_tlast)
  );

  assign m_tdata = {status, count, value_out};

endmodule

[hw/rtl/pli_ctrl.sv]
module pli_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  output logic          m_tvalid,
  input  logic          m_tready,
  input  pli_pkg::sts_t sts,
  output pli_pkg::cmd_t cmd
);
  import pli_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_DISP
  } state_t;

  state_t state;
  logic   slot_free;
  logic   accept;

  // output register can take a beat this cycle
  assign slot_free = !m_tvalid || m_tready;
  assign s_tready  = (state == S_IDLE) && slot_free;
  assign accept    = s_tvalid && s_tready;

  // command decode
  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.exec       = !sts.disp_run;
          cmd.disp_start = sts.disp_run;
        end
      end
      S_DISP: begin
        cmd.disp_load = slot_free;
      end
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.exec || cmd.disp_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd.disp_start) begin
            state <= S_DISP;
          end
        end
        S_DISP: begin
          if (cmd.disp_load && sts.disp_last) begin
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

[hw/rtl/pli_dp.sv]
module pli_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  pli_pkg::cmd_t                    cmd,
  output pli_pkg::sts_t                    sts,
  input  logic [pli_pkg::OP_W-1:0]         opcode,
  input  logic signed [pli_pkg::VALUE_W-1:0] value,
  input  logic [pli_pkg::POS_W-1:0]        position,
  output logic signed [pli_pkg::VALUE_W-1:0] value_out,
  output logic                             value_valid,
  output logic [pli_pkg::CNT_OUT_W-1:0]    count,
  output logic [pli_pkg::STATUS_W-1:0]     status,
  output logic                             last
);
  import pli_pkg::*;

  logic signed [VALUE_W-1:0] cells [DEPTH];
  logic [COUNT_W-1:0]        cnt;
  logic [COUNT_W-1:0]        cnt_next;
  logic [INDEX_W-1:0]        disp_idx;

  op_t                res_op;
  status_t            res_status;
  logic               do_ins;
  logic               do_del;
  logic [COUNT_W-1:0] op_idx;
  logic               is_full;
  logic               is_empty;
  logic [CMP_W-1:0]   pos_ext;
  logic [CMP_W-1:0]   cnt_ext;
  logic [POS_W-1:0]   pos_m1;

  assign res_op   = op_t'(opcode);
  assign is_full  = (cnt == COUNT_W'(DEPTH));
  assign is_empty = (cnt == '0);
  assign pos_ext  = CMP_W'(position);
  assign cnt_ext  = CMP_W'(cnt);
  assign pos_m1   = position - POS_W'(1);

  // operation decode and bounds checks
  always_comb begin
    res_status = STAT_OK;
    do_ins     = 1'b0;
    do_del     = 1'b0;
    op_idx     = '0;
    unique case (res_op)
      OP_INS_FRONT: begin
        if (is_full) res_status = STAT_FULL;
        else do_ins = 1'b1;
      end
      OP_INS_BACK: begin
        op_idx = cnt;
        if (is_full) res_status = STAT_FULL;
        else do_ins = 1'b1;
      end
      OP_INS_POS: begin
        op_idx = COUNT_W'(pos_m1);
        if (position == '0 || pos_ext > cnt_ext + CMP_W'(1)) res_status = STAT_BADPOS;
        else if (is_full) res_status = STAT_FULL;
        else do_ins = 1'b1;
      end
      OP_DEL_FRONT: begin
        if (is_empty) res_status = STAT_EMPTY;
        else do_del = 1'b1;
      end
      OP_DEL_BACK: begin
        op_idx = cnt - COUNT_W'(1);
        if (is_empty) res_status = STAT_EMPTY;
        else do_del = 1'b1;
      end
      OP_DEL_POS: begin
        op_idx = COUNT_W'(pos_m1);
        if (position == '0 || pos_ext > cnt_ext) res_status = STAT_BADPOS;
        else do_del = 1'b1;
      end
      OP_DISPLAY: begin
        // only an empty list reaches here
        res_status = STAT_EMPTY;
      end
      default: begin
        res_status = STAT_OK;
      end
    endcase
  end

  assign cnt_next = do_ins ? cnt + COUNT_W'(1) :
                    do_del ? cnt - COUNT_W'(1) : cnt;

  assign sts.disp_run  = (res_op == OP_DISPLAY) && !is_empty;
  assign sts.disp_last = (COUNT_W'(disp_idx) + COUNT_W'(1)) == cnt;

  // entry count and readout index
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      disp_idx <= '0;
    end else begin
      if (cmd.exec) begin
        cnt <= cnt_next;
      end
      if (cmd.disp_start) begin
        disp_idx <= '0;
      end else if (cmd.disp_load) begin
        disp_idx <= disp_idx + INDEX_W'(1);
      end
    end
  end

  // cells shift in parallel: open a gap on insert, close it on delete
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (do_ins) begin
          if (COUNT_W'(i) == op_idx) begin
            cells[INDEX_W'(i)] <= value;
          end else if (i > 0 && COUNT_W'(i) > op_idx) begin
            cells[INDEX_W'(i)] <= cells[INDEX_W'((i > 0) ? i - 1 : 0)];
          end
        end else if (do_del) begin
          if (i < DEPTH - 1 && COUNT_W'(i) >= op_idx) begin
            cells[INDEX_W'(i)] <= cells[INDEX_W'((i < DEPTH - 1) ? i + 1 : i)];
          end
        end
      end
    end
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      value_out   <= '0;
      value_valid <= 1'b0;
      count       <= CNT_OUT_W'(cnt_next);
      status      <= res_status;
      last        <= 1'b1;
    end else if (cmd.disp_load) begin
      value_out   <= cells[disp_idx];
      value_valid <= 1'b1;
      count       <= CNT_OUT_W'(cnt);
      status      <= STAT_OK;
      last        <= sts.disp_last;
    end
  end

endmodule

[hw/rtl/pli_chk.sv]
module pli_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [pli_pkg::M_TDATA_W-1:0] m_tdata,
  input logic                          m_tuser,
  input logic                          m_tlast
);
  import pli_pkg::*;

  // no new operation while a result beat is stalled
  a_no_take_on_stall: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken while output stalled");

  // count never exceeds the list depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[37:32] <= CNT_OUT_W'(DEPTH)))
    else $error("count above depth");

  // a beat without an entry is always the only beat of its operation
  a_plain_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> m_tlast)
    else $error("non-entry beat without tlast");

  // display entries always carry status ok
  a_entry_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[39:38] == STAT_OK))
    else $error("entry beat with bad status");

  // a stalled beat stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid)
    else $error("output beat dropped while stalled");

endmodule

bind positional_list_insert_delete pli_chk u_pli_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
